// ===== hdl/rational_arith_reduce_unit_defines.svh =====
// Assertion macros for the rational reduce unit
`ifndef RATIONAL_ARITH_REDUCE_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_UNIT_DEFINES_SVH
// check that a condition implies a consequence on the same edge
`define RAR_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// check that a condition implies a consequence on the following edge
`define RAR_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/rar_pkg.sv =====
// Package: widths, operation codes and status codes for the rational unit
package rar_pkg;
  localparam int WIDTH = 32;
  localparam int MW = 64;
  localparam int CW = 7;

  localparam logic [2:0] KIND_NORM = 3'd0;
  localparam logic [2:0] KIND_ADD  = 3'd1;
  localparam logic [2:0] KIND_SUB  = 3'd2;
  localparam logic [2:0] KIND_MUL  = 3'd3;
  localparam logic [2:0] KIND_DIV  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic         start;
    logic [MW-1:0] dividend;
    logic [MW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic         done;
    logic [MW-1:0] quot;
    logic [MW-1:0] rem;
  } div_rsp_t;
endpackage

// ===== hdl/rational_arith_reduce_unit.sv =====
// Top level: operand split, cross products, Euclid GCD and reduction
// Flow: S_MUL1-S_MUL3 and S_COMB, then Euclid steps (S_GCD/S_GWT) and the two reductions
// (S_DIVN, S_DIVD), all on the shared 64-bit bit-serial divider, then S_OUT;
// a zero denominator or divisor goes from S_MUL1 straight to S_OUT.
// One item at a time: busy stays high through out_valid, so no new item is taken before then;
// result shows for one cycle, the receiver cannot stall. Sync reset drops busy/out_valid.
`include "rational_arith_reduce_unit_defines.svh"
module rational_arith_reduce_unit
  import rar_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic [1:0]         out_status
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MUL1 = 10'b0000000010,
    S_MUL2 = 10'b0000000100,
    S_MUL3 = 10'b0000001000,
    S_COMB = 10'b0000010000,
    S_GCD  = 10'b0000100000,
    S_GWT  = 10'b0001000000,
    S_DIVN = 10'b0010000000,
    S_DIVD = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t        st_r, st_nxt;
  logic [2:0]    kind_r;
  logic [31:0]   an_r, ad_r, bn_r, bd_r;
  logic          sa_r, sb_r;
  logic [MW-1:0] p0_r, p1_r, p2_r;
  logic [MW-1:0] mag_r, den_r, x_r, y_r;
  logic          neg_r;
  logic [1:0]    stat_r;
  logic          ov_r;
  logic [31:0]   onum_r;
  logic [30:0]   oden_r;
  logic [1:0]    ost_r;
  logic [31:0]   ma, mb;
  logic [MW-1:0] prod;
  logic          s2;
  div_req_t      dreq;
  div_rsp_t      drsp;
  logic [MW-1:0] lim;
  logic          acc;
  // sub-phase flag for S_DIVN/S_DIVD: 0 = launch, 1 = wait
  logic          wait_r;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  assign acc  = start && !busy;
  assign lim  = MW'(1) << (WIDTH - 1);
  assign prod = MW'(ma) * MW'(mb);
  assign s2   = (kind_r == KIND_SUB) ? !sb_r : sb_r;

  // one shared 32x32 multiplier, operands chosen per step
  always_comb begin
    ma = an_r;
    mb = bd_r;
    case (st_r)
      S_MUL1: begin
        ma = ad_r;
        mb = (kind_r == KIND_DIV) ? bn_r : bd_r;
      end
      S_MUL2: begin
        ma = (kind_r == KIND_MUL) ? an_r : bn_r;
        mb = (kind_r == KIND_MUL) ? bn_r : ad_r;
      end
      default: begin
        ma = an_r;
        mb = bd_r;
      end
    endcase
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = x_r;
    dreq.divisor  = y_r;
    case (st_r)
      S_GCD:  dreq.start = 1'b1;
      S_DIVN: begin
        dreq.start    = !wait_r;
        dreq.dividend = mag_r;
        dreq.divisor  = x_r;
      end
      S_DIVD: begin
        dreq.start    = !wait_r;
        dreq.dividend = den_r;
        dreq.divisor  = x_r;
      end
      default: dreq.start = 1'b0;
    endcase
  end

  rar_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (acc) st_nxt = S_MUL1;
      S_MUL1: st_nxt = (stat_r != ST_OK) ? S_OUT : S_MUL2;
      S_MUL2: st_nxt = S_MUL3;
      S_MUL3: st_nxt = S_COMB;
      // a zero numerator runs one Euclid step and reduces to 0/1
      S_COMB: st_nxt = S_GCD;
      S_GCD:  st_nxt = S_GWT;
      S_GWT:  if (drsp.done) st_nxt = (drsp.rem == '0) ? S_DIVN : S_GCD;
      S_DIVN: if (wait_r && drsp.done) st_nxt = S_DIVD;
      S_DIVD: if (wait_r && drsp.done) st_nxt = S_OUT;
      S_OUT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      wait_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= (st_r == S_OUT);
      if (st_r == S_DIVN || st_r == S_DIVD)
        wait_r <= wait_r ? !drsp.done : 1'b1;
      else
        wait_r <= 1'b0;
    end
    case (st_r)
      S_IDLE: if (acc) begin
        kind_r <= in_kind;
        an_r   <= mag32(in_a_num);
        ad_r   <= mag32(in_a_den);
        bn_r   <= mag32(in_b_num);
        bd_r   <= mag32(in_b_den);
        sa_r   <= in_a_num[31] ^ in_a_den[31];
        sb_r   <= in_b_num[31] ^ in_b_den[31];
        if (in_a_den == '0 ||
            ((in_kind == KIND_ADD || in_kind == KIND_SUB || in_kind == KIND_MUL ||
              in_kind == KIND_DIV) && in_b_den == '0) ||
            (in_kind == KIND_DIV && in_b_num == '0))
          stat_r <= ST_ZERO;
        else
          stat_r <= ST_OK;
      end
      S_MUL1: p0_r <= prod;
      S_MUL2: p1_r <= prod;
      S_MUL3: p0_r <= prod;
      default: ;
    endcase
    if (st_r == S_MUL3) begin
      p2_r <= p0_r;
    end
    if (st_r == S_COMB) begin
      // p0_r: an*bd; p1_r: an*bn (mul) or bn*ad; p2_r: denominator product
      case (kind_r)
        KIND_ADD, KIND_SUB: begin
          if (sa_r == s2) begin
            mag_r <= p0_r + p1_r;
            neg_r <= sa_r;
          end else if (p0_r >= p1_r) begin
            mag_r <= p0_r - p1_r;
            neg_r <= sa_r;
          end else begin
            mag_r <= p1_r - p0_r;
            neg_r <= s2;
          end
          den_r <= p2_r;
        end
        KIND_MUL: begin
          mag_r <= p1_r;
          den_r <= p2_r;
          neg_r <= sa_r ^ sb_r;
        end
        KIND_DIV: begin
          mag_r <= p0_r;
          den_r <= p2_r;
          neg_r <= sa_r ^ sb_r;
        end
        default: begin
          mag_r <= MW'(an_r);
          den_r <= MW'(ad_r);
          neg_r <= sa_r;
        end
      endcase
    end
    if (st_r == S_COMB) begin
      case (kind_r)
        KIND_ADD, KIND_SUB: begin
          if (sa_r == s2) x_r <= p0_r + p1_r;
          else if (p0_r >= p1_r) x_r <= p0_r - p1_r;
          else x_r <= p1_r - p0_r;
        end
        KIND_MUL: x_r <= p1_r;
        KIND_DIV: x_r <= p0_r;
        default: x_r <= MW'(an_r);
      endcase
      y_r <= (kind_r == KIND_ADD || kind_r == KIND_SUB || kind_r == KIND_MUL ||
              kind_r == KIND_DIV) ? p2_r : MW'(ad_r);
    end
    if (st_r == S_GWT && drsp.done && drsp.rem != '0) begin
      x_r <= y_r;
      y_r <= drsp.rem;
    end
    if (st_r == S_GWT && drsp.done && drsp.rem == '0) x_r <= y_r;
    if (st_r == S_DIVN && wait_r && drsp.done) mag_r <= drsp.quot;
    if (st_r == S_DIVD && wait_r && drsp.done) den_r <= drsp.quot;
    if (st_r == S_OUT) begin
      if (stat_r != ST_OK) begin
        onum_r <= '0;
        oden_r <= '0;
        ost_r  <= stat_r;
      end else if (mag_r == '0) begin
        onum_r <= '0;
        oden_r <= 31'd1;
        ost_r  <= ST_OK;
      end else if ((neg_r ? (mag_r > lim) : (mag_r >= lim)) || den_r >= lim) begin
        onum_r <= '0;
        oden_r <= '0;
        ost_r  <= ST_OVF;
      end else begin
        onum_r <= neg_r ? (32'd0 - mag_r[31:0]) : mag_r[31:0];
        oden_r <= den_r[30:0];
        ost_r  <= ST_OK;
      end
    end
  end

  // divider dividend for S_DIVN/S_DIVD must only launch once
  assign busy        = (st_r != S_IDLE) || ov_r;
  assign out_valid   = ov_r;
  assign out_res_num = onum_r;
  assign out_res_den = oden_r;
  assign out_status  = ost_r;

  `RAR_ASSERT_NXT(a_start_leaves_idle, clk, rst_n, start && !busy, st_r == S_MUL1)
  `RAR_ASSERT_NXT(a_out_one_cycle, clk, rst_n, out_valid, !out_valid)
  `RAR_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_status != ST_OK,
                  out_res_num == '0 && out_res_den == '0)
endmodule

// ===== hdl/rar_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle
module rar_divider
  import rar_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0] q_r, q_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [MW-1:0] dvs_r, dvs_nxt;
  logic          done_r, done_nxt;
  logic [MW:0]   trial;
  logic [MW:0]   diff;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[MW-1]};
    diff     = trial - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!diff[MW]) begin
        rem_nxt = diff[MW-1:0];
        q_nxt   = {q_r[MW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[MW-1:0];
        q_nxt   = {q_r[MW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(MW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the rational arithmetic reduce unit
`timescale 1ns / 1ps
module tb_top
  import rar_pkg::*;
();

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } op_beat_t;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic [1:0]         status;
  } frac_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_kind = '0;
  logic signed [31:0] in_a_num = '0;
  logic signed [31:0] in_a_den = '0;
  logic signed [31:0] in_b_num = '0;
  logic signed [31:0] in_b_den = '0;
  logic               out_valid;
  logic signed [31:0] out_res_num;
  logic [30:0]        out_res_den;
  logic [1:0]         out_status;

  op_beat_t   op_queue[$];
  frac_beat_t expected_fracs[$];
  int         mismatches = 0;
  int         cycle_count = 0;
  int         gap_left = 0;
  bit         stim_done = 0;
  bit         timed_out = 0;

  rational_arith_reduce_unit u_top (.*);

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0d: %s", cycle_count, what);
    mismatches++;
  endtask

  function automatic logic [31:0] mag_of(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_beat_t reduce_op(input op_beat_t op);
    frac_beat_t r;
    logic [63:0] an, ad, bn, bd, t1, t2, mag, den, g, lim;
    logic sa, sb, s2, neg, binop;
    logic [1:0] st;
    an = mag_of(op.a_num); ad = mag_of(op.a_den);
    bn = mag_of(op.b_num); bd = mag_of(op.b_den);
    sa = op.a_num[31] ^ op.a_den[31];
    sb = op.b_num[31] ^ op.b_den[31];
    binop = op.kind inside {KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV};
    mag = 0; den = 1; neg = 0; st = ST_OK;
    lim = 64'd1 << (WIDTH - 1);
    if (ad == 0 || (binop && bd == 0) || (op.kind == KIND_DIV && bn == 0)) begin
      st = ST_ZERO;
    end else begin
      case (op.kind)
        KIND_ADD, KIND_SUB: begin
          t1 = an * bd;
          t2 = bn * ad;
          s2 = (op.kind == KIND_SUB) ? !sb : sb;
          if (sa == s2) begin
            mag = t1 + t2; neg = sa;
          end else if (t1 >= t2) begin
            mag = t1 - t2; neg = sa;
          end else begin
            mag = t2 - t1; neg = s2;
          end
          den = ad * bd;
        end
        KIND_MUL: begin
          mag = an * bn; den = ad * bd; neg = sa ^ sb;
        end
        KIND_DIV: begin
          mag = an * bd; den = ad * bn; neg = sa ^ sb;
        end
        default: begin
          mag = an; den = ad; neg = sa;
        end
      endcase
      if (mag == 0) begin
        den = 1; neg = 0;
      end else begin
        g = gcd64(mag, den);
        mag = mag / g;
        den = den / g;
        if ((neg ? (mag > lim) : (mag >= lim)) || den >= lim) st = ST_OVF;
      end
    end
    if (st != ST_OK) begin
      r.num = '0; r.den = '0;
    end else begin
      r.num = neg ? (32'd0 - mag[31:0]) : mag[31:0];
      r.den = den[30:0];
    end
    r.status = st;
    return r;
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 40) - 20;
      2: return $urandom_range(1, 1000) * (($urandom & 1) ? -1 : 1);
      3: return {1'($urandom_range(0, 1)), 31'h7fff_ffff} ^ {32{1'($urandom)}};
      4: return $urandom & 32'h0000_ffff;
      default: return 32'sd1 << $urandom_range(0, 31);
    endcase
  endfunction

  task automatic push_op(input logic [2:0] k, input logic [31:0] an, input logic [31:0] ad,
                         input logic [31:0] bn, input logic [31:0] bd);
    op_beat_t op;
    op.kind = k; op.a_num = an; op.a_den = ad; op.b_num = bn; op.b_den = bd;
    op_queue.push_back(op);
  endtask

  initial begin
    op_beat_t op;
    logic [31:0] mn, mx;
    mn = 32'h8000_0000; mx = 32'h7fff_ffff;
    push_op(KIND_NORM, 6, -4, 0, 0);
    push_op(KIND_NORM, 0, 7, 0, 0);
    push_op(KIND_NORM, 5, 0, 0, 0);
    push_op(KIND_ADD, 1, 2, 1, 3);
    push_op(KIND_SUB, 3, 1, 5, 1);
    push_op(KIND_MUL, -2, 3, 3, -4);
    push_op(KIND_DIV, 2, 3, 5, 1);
    push_op(KIND_DIV, 2, 3, 0, 7);
    push_op(KIND_DIV, 7, 1, 2, 3);
    push_op(KIND_ADD, 1, 2, 1, 0);
    push_op(KIND_NORM, mn, 1, 0, 0);
    push_op(KIND_NORM, mn, -1, 0, 0);
    push_op(KIND_NORM, mx, mn, 0, 0);
    push_op(KIND_NORM, 1, mn, 0, 0);
    push_op(KIND_MUL, mx, 1, mx, 1);
    push_op(KIND_ADD, mx, 1, mx, 1);
    push_op(KIND_SUB, mn, 1, mx, 1);
    push_op(KIND_DIV, mn, mx, mn, mx);
    push_op(KIND_MUL, mn, mn, mn, mn);
    push_op(3'd5, 4, 8, 0, 0);
    push_op(3'd6, -9, 3, 1, 0);
    push_op(3'd7, mx, mx, mn, 0);
    push_op(KIND_SUB, 1, 3, 1, 3);
    for (int i = 0; i < 1750; i++) begin
      op.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
      op.a_num = rand_field(); op.a_den = rand_field();
      op.b_num = rand_field();
      op.b_den = ($urandom_range(0, 3) == 0) ? 32'sd1 : rand_field();
      op_queue.push_back(op);
    end
    stim_done = 1;
  end

  // driver: start drops only on the edge that accepts a beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        start <= 1'b0;
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
      end else if (!start && op_queue.size() > 0) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else begin
          op_beat_t op;
          op = op_queue.pop_front();
          expected_fracs.push_back(reduce_op(op));
          in_kind <= op.kind; in_a_num <= op.a_num; in_a_den <= op.a_den;
          in_b_num <= op.b_num; in_b_den <= op.b_den;
          start <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_fracs.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        frac_beat_t e;
        e = expected_fracs.pop_front();
        if (out_res_num !== e.num)
          report_mismatch($sformatf("num got %0d exp %0d", out_res_num, e.num));
        if (out_res_den !== e.den)
          report_mismatch($sformatf("den got %0d exp %0d", out_res_den, e.den));
        if (out_status !== e.status)
          report_mismatch($sformatf("status got %0d exp %0d", out_status, e.status));
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // worst item runs the longest Euclid chain plus gaps; allow several times the slowest run
    fork
      begin
        wait (stim_done && op_queue.size() == 0 && !start && expected_fracs.size() == 0);
        repeat (50) @(posedge clk);
      end
      begin
        wait (cycle_count >= 60_000_000);
        timed_out = 1;
      end
    join_any
    if (timed_out) begin
      $display("simulation failed");
    end else if (mismatches == 0 && expected_fracs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/rar_pkg.sv
hdl/rar_divider.sv
hdl/rational_arith_reduce_unit.sv
dv/tb_top.sv
